// ===== rtl/assert_macros.svh =====
// assertion helpers for the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked out of reset
`define LPHT_ASSERT_IMP(name, clk, rst_n, pre, post) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("same-cycle check failed");

// next-cycle implication, checked out of reset
`define LPHT_ASSERT_NXT(name, clk, rst_n, pre, post) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("next-cycle check failed");

`endif

// ===== rtl/lpht_pkg.sv =====
package lpht_pkg;

    // payload field widths
    localparam int OPCODE_W    = 2;
    localparam int KEY_W       = 31;
    localparam int IN_DATA_W   = 32;
    localparam int STATUS_W    = 2;
    localparam int SLOT_W      = 4;
    localparam int OUT_DATA_W  = 32;

    // stream data widths, padded to whole bytes
    localparam int IN_FIELDS_W  = OPCODE_W + KEY_W + IN_DATA_W;
    localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = STATUS_W + SLOT_W + OUT_DATA_W;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

    // parameter defaults
    localparam int TABLE_SIZE_DEF = 16;
    localparam int DATA_WIDTH_DEF = 32;

    // home slot reduction steps: reciprocal multiply, then subtract
    localparam int HASH_STEPS = 2;
    localparam int STEP_W     = 1;

    typedef enum logic [OPCODE_W-1:0] {
        OP_CLEAR  = 2'd0,
        OP_INSERT = 2'd1,
        OP_SEARCH = 2'd2
    } t_opcode;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK   = 2'd0,
        ST_MISS = 2'd1,
        ST_FULL = 2'd2
    } t_status;

    // controller to datapath
    typedef struct packed {
        logic    accept;
        logic    hash_step;
        logic    probe_start;
        logic    probe_next;
        logic    sweep_start;
        logic    sweep_step;
        logic    write_slot;
        logic    res_set;
        t_status res_status;
        logic    res_slot;
        logic    res_data;
        logic    out_load;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic [OPCODE_W-1:0] op;
        logic                hash_done;
        logic                slot_valid;
        logic                key_match;
        logic                last_probe;
        logic                sweep_last;
        logic                out_free;
    } t_stat;

endpackage

// ===== rtl/linear_probe_hash_table_top.sv =====
// insert/search: result follows the home slot reduction and P probed slots, P = 1..TABLE_SIZE
// clear: result follows a sweep over every slot; unused opcode: a plain ok reply
// one request at a time; the next request is taken once the result sits in the output register
// cost: home slot reduction by reciprocal multiply, then one table read per probed slot
// reset: synchronous active low; a clearing pass over every slot follows with tready low
module linear_probe_hash_table_top #(
    parameter int TABLE_SIZE = lpht_pkg::TABLE_SIZE_DEF,
    parameter int DATA_WIDTH = lpht_pkg::DATA_WIDTH_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // request stream
    input  logic                               i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    // opcode [1:0], key [32:2], item_data [64:33], zero fill above
    input  logic [lpht_pkg::IN_TDATA_W-1:0]    i_s_axis_tdata,
    // result stream
    output logic                               o_m_axis_tvalid,
    input  logic                               i_m_axis_tready,
    // status [1:0], slot_index [5:2], data_out [37:6], zero fill above
    output logic [lpht_pkg::OUT_TDATA_W-1:0]   o_m_axis_tdata
);
    import lpht_pkg::*;

    `include "assert_macros.svh"

    localparam int KEY_LO  = OPCODE_W;
    localparam int DATA_LO = OPCODE_W + KEY_W;

    t_cmd  cmd;
    t_stat stat;

    logic [OPCODE_W-1:0]   in_op;
    logic [KEY_W-1:0]      in_key;
    logic [IN_DATA_W-1:0]  in_data;
    logic [STATUS_W-1:0]   out_status;
    logic [SLOT_W-1:0]     out_slot;
    logic [OUT_DATA_W-1:0] out_data;

    // unpack the request fields
    assign in_op   = i_s_axis_tdata[OPCODE_W-1:0];
    assign in_key  = i_s_axis_tdata[KEY_LO +: KEY_W];
    assign in_data = i_s_axis_tdata[DATA_LO +: IN_DATA_W];

    // sequencer: sweep, hash, probe, reply
    lpht_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .i_in_op    (in_op),
        .o_in_ready (o_s_axis_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    // slot memory, hash unit, probe pointer and output register
    lpht_dp #(
        .TABLE_SIZE (TABLE_SIZE),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .i_in_op      (in_op),
        .i_in_key     (in_key),
        .i_in_data    (in_data),
        .o_out_valid  (o_m_axis_tvalid),
        .i_out_ready  (i_m_axis_tready),
        .o_out_status (out_status),
        .o_out_slot   (out_slot),
        .o_out_data   (out_data)
    );

    // pack the result fields
    assign o_m_axis_tdata = {{(OUT_TDATA_W - OUT_FIELDS_W){1'b0}}, out_data, out_slot, out_status};

    // a result only moves into the output register when that register is free
    `LPHT_ASSERT_IMP(a_load_free, i_clk, i_rst_n, cmd.out_load, stat.out_free)
    // insert only ever writes an empty slot, and never during a sweep
    `LPHT_ASSERT_IMP(a_write_empty, i_clk, i_rst_n, cmd.write_slot, !stat.slot_valid && !cmd.sweep_step)
    // one request in flight: ready drops right after a request is taken
    `LPHT_ASSERT_NXT(a_one_req, i_clk, i_rst_n, i_s_axis_tvalid && o_s_axis_tready, !o_s_axis_tready)

endmodule

// ===== rtl/lpht_ctrl.sv =====
module lpht_ctrl (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  logic [lpht_pkg::OPCODE_W-1:0] i_in_op,
    output logic                          o_in_ready,
    input  lpht_pkg::t_stat               i_stat,
    output lpht_pkg::t_cmd                o_cmd
);
    import lpht_pkg::*;

    typedef enum logic [6:0] {
        S_INIT  = 7'b0000001,
        S_IDLE  = 7'b0000010,
        S_HASH  = 7'b0000100,
        S_READ  = 7'b0001000,
        S_PROBE = 7'b0010000,
        S_CLEAR = 7'b0100000,
        S_RESP  = 7'b1000000
    } t_state;

    t_state r_state;
    t_state n_state;

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_INIT: begin
                o_cmd.sweep_step = 1'b1;
                if (i_stat.sweep_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    unique case (i_in_op)
                        OP_CLEAR: begin
                            o_cmd.sweep_start = 1'b1;
                            n_state           = S_CLEAR;
                        end
                        OP_INSERT, OP_SEARCH: begin
                            n_state = S_HASH;
                        end
                        default: begin
                            // unused opcode: plain ok reply
                            o_cmd.res_set    = 1'b1;
                            o_cmd.res_status = ST_OK;
                            n_state          = S_RESP;
                        end
                    endcase
                end
            end
            S_HASH: begin
                o_cmd.hash_step = 1'b1;
                if (i_stat.hash_done) begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                o_cmd.probe_start = 1'b1;
                n_state           = S_PROBE;
            end
            S_PROBE: begin
                if (i_stat.op == OP_INSERT) begin
                    priority if (!i_stat.slot_valid) begin
                        o_cmd.write_slot = 1'b1;
                        o_cmd.res_set    = 1'b1;
                        o_cmd.res_status = ST_OK;
                        o_cmd.res_slot   = 1'b1;
                        n_state          = S_RESP;
                    end else if (i_stat.last_probe) begin
                        o_cmd.res_set    = 1'b1;
                        o_cmd.res_status = ST_FULL;
                        n_state          = S_RESP;
                    end else begin
                        o_cmd.probe_next = 1'b1;
                    end
                end else begin
                    priority if (!i_stat.slot_valid) begin
                        o_cmd.res_set    = 1'b1;
                        o_cmd.res_status = ST_MISS;
                        n_state          = S_RESP;
                    end else if (i_stat.key_match) begin
                        o_cmd.res_set    = 1'b1;
                        o_cmd.res_status = ST_OK;
                        o_cmd.res_slot   = 1'b1;
                        o_cmd.res_data   = 1'b1;
                        n_state          = S_RESP;
                    end else if (i_stat.last_probe) begin
                        o_cmd.res_set    = 1'b1;
                        o_cmd.res_status = ST_MISS;
                        n_state          = S_RESP;
                    end else begin
                        o_cmd.probe_next = 1'b1;
                    end
                end
            end
            S_CLEAR: begin
                o_cmd.sweep_step = 1'b1;
                if (i_stat.sweep_last) begin
                    o_cmd.res_set    = 1'b1;
                    o_cmd.res_status = ST_OK;
                    n_state          = S_RESP;
                end
            end
            S_RESP: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_INIT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== rtl/lpht_dp.sv =====
module lpht_dp #(
    parameter int TABLE_SIZE = lpht_pkg::TABLE_SIZE_DEF,
    parameter int DATA_WIDTH = lpht_pkg::DATA_WIDTH_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  lpht_pkg::t_cmd                   i_cmd,
    output lpht_pkg::t_stat                  o_stat,
    input  logic [lpht_pkg::OPCODE_W-1:0]    i_in_op,
    input  logic [lpht_pkg::KEY_W-1:0]       i_in_key,
    input  logic [lpht_pkg::IN_DATA_W-1:0]   i_in_data,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic [lpht_pkg::STATUS_W-1:0]    o_out_status,
    output logic [lpht_pkg::SLOT_W-1:0]      o_out_slot,
    output logic [lpht_pkg::OUT_DATA_W-1:0]  o_out_data
);
    import lpht_pkg::*;

    localparam int IDX_W  = $clog2(TABLE_SIZE);
    localparam int REM_W  = IDX_W + 1;
    localparam int WORD_W = 1 + KEY_W + DATA_WIDTH;
    localparam logic [REM_W-1:0] TS_REM   = REM_W'(TABLE_SIZE);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_SIZE - 1);

    // key / TABLE_SIZE as (key * RECIP) >> QSHIFT, exact over the whole key range
    localparam int RECIP_W = KEY_W + 1;
    localparam int PROD_W  = KEY_W + RECIP_W;
    localparam int QSHIFT  = KEY_W + IDX_W;
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'(((64'd1 << QSHIFT) / 64'(TABLE_SIZE)) + 64'd1);

    // slot word: valid, key, payload
    logic [WORD_W-1:0] mem [TABLE_SIZE];

    logic [OPCODE_W-1:0]   r_op;
    logic [KEY_W-1:0]      r_key;
    logic [DATA_WIDTH-1:0] r_data;
    logic [PROD_W-1:0]     r_prod;
    logic [REM_W-1:0]      quo_lo;
    logic [REM_W-1:0]      r_rem;
    logic [REM_W-1:0]      n_rem;
    logic [STEP_W-1:0]     r_step;
    logic [IDX_W-1:0]      r_pos;
    logic [IDX_W-1:0]      r_cnt;
    logic [IDX_W-1:0]      next_pos;
    logic [IDX_W-1:0]      rd_addr;
    logic [WORD_W-1:0]     r_rdata;
    logic [WORD_W-1:0]     wr_word;

    logic                  rd_valid;
    logic [KEY_W-1:0]      rd_key;
    logic [DATA_WIDTH-1:0] rd_payload;

    t_status               r_res_status;
    logic [IDX_W-1:0]      r_res_slot;
    logic [DATA_WIDTH-1:0] r_res_data;

    logic                  r_out_valid;
    t_status               r_out_status;
    logic [IDX_W-1:0]      r_out_slot;
    logic [DATA_WIDTH-1:0] r_out_data;

    // home slot: key minus quotient times table size, only the low bits matter
    assign quo_lo = r_prod[QSHIFT +: REM_W];
    assign n_rem  = r_key[REM_W-1:0] - quo_lo * TS_REM;

    assign next_pos   = (r_pos == LAST_IDX) ? '0 : r_pos + 1'b1;
    assign rd_addr    = i_cmd.probe_start ? r_rem[IDX_W-1:0] : next_pos;
    assign rd_valid   = r_rdata[WORD_W-1];
    assign rd_key     = r_rdata[WORD_W-2 -: KEY_W];
    assign rd_payload = r_rdata[DATA_WIDTH-1:0];
    assign wr_word    = i_cmd.sweep_step ? '0 : {1'b1, r_key, r_data};

    always_ff @(posedge i_clk) begin
        if (i_cmd.sweep_step || i_cmd.write_slot) begin
            mem[r_pos] <= wr_word;
        end
        r_rdata <= mem[rd_addr];
    end

    // request capture and hashing
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_op   <= i_in_op;
            r_key  <= i_in_key;
            r_data <= DATA_WIDTH'(i_in_data);
        end else if (i_cmd.hash_step) begin
            r_prod <= PROD_W'(r_key) * PROD_W'(RECIP);
            r_rem  <= n_rem;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= '0;
            r_pos  <= '0;
            r_cnt  <= '0;
        end else begin
            if (i_cmd.accept) begin
                r_step <= '0;
            end else if (i_cmd.hash_step) begin
                r_step <= r_step + 1'b1;
            end
            priority if (i_cmd.sweep_start) begin
                r_pos <= '0;
            end else if (i_cmd.probe_start) begin
                r_pos <= r_rem[IDX_W-1:0];
                r_cnt <= '0;
            end else if (i_cmd.probe_next || i_cmd.sweep_step) begin
                r_pos <= next_pos;
                r_cnt <= r_cnt + 1'b1;
            end else begin
                r_pos <= r_pos;
            end
        end
    end

    // pending result
    always_ff @(posedge i_clk) begin
        if (i_cmd.res_set) begin
            r_res_status <= i_cmd.res_status;
            r_res_slot   <= i_cmd.res_slot ? r_pos : '0;
            r_res_data   <= i_cmd.res_data ? rd_payload : '0;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_status <= r_res_status;
            r_out_slot   <= r_res_slot;
            r_out_data   <= r_res_data;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_status = r_out_status;
    assign o_out_slot   = SLOT_W'(r_out_slot);
    assign o_out_data   = OUT_DATA_W'(r_out_data);

    assign o_stat.op         = r_op;
    assign o_stat.hash_done  = (r_step == STEP_W'(HASH_STEPS - 1));
    assign o_stat.slot_valid = rd_valid;
    assign o_stat.key_match  = (rd_key == r_key);
    assign o_stat.last_probe = (r_cnt == LAST_IDX);
    assign o_stat.sweep_last = (r_pos == LAST_IDX);
    assign o_stat.out_free   = !r_out_valid || i_out_ready;

endmodule

// ===== tb/lpht_result_checker.sv =====
module lpht_result_checker (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_req_valid,
    input  logic                             i_req_ready,
    // opcode, key, item_data from bit 0 up, zero fill above
    input  logic [lpht_pkg::IN_TDATA_W-1:0]  i_req_data,
    input  logic                             i_res_valid,
    input  logic                             i_res_ready,
    // status, slot_index, data_out from bit 0 up, zero fill above
    input  logic [lpht_pkg::OUT_TDATA_W-1:0] i_res_data,
    output int                               o_fail_count,
    output int                               o_pending,
    output int                               o_checked,
    output int                               o_hits,
    output int                               o_misses,
    output int                               o_fulls
);
    import lpht_pkg::*;

    localparam int SLOTS      = TABLE_SIZE_DEF;

    typedef struct packed {
        t_status               status;
        logic [SLOT_W-1:0]     slot;
        logic [OUT_DATA_W-1:0] payload;
    } t_lookup;

    logic                  occupied       [SLOTS];
    logic [KEY_W-1:0]      stored_key     [SLOTS];
    logic [OUT_DATA_W-1:0] stored_payload [SLOTS];
    t_lookup               expected_q     [$];

    int fail_count = 0;
    int checked    = 0;
    int hits       = 0;
    int misses     = 0;
    int fulls      = 0;

    // table model: updates the slots and returns the answer the block owes
    function automatic t_lookup apply_request(input logic [OPCODE_W-1:0]  op,
                                              input logic [KEY_W-1:0]     key,
                                              input logic [IN_DATA_W-1:0] item);
        t_lookup res;
        int      pos;
        bit      done;
        res  = '0;
        pos  = key % SLOTS;
        done = 1'b0;
        case (op)
            OP_CLEAR: begin
                for (int i = 0; i < SLOTS; i++) occupied[i] = 1'b0;
            end
            OP_INSERT: begin
                res.status = ST_FULL;
                for (int n = 0; n < SLOTS && !done; n++) begin
                    if (!occupied[pos]) begin
                        occupied[pos]       = 1'b1;
                        stored_key[pos]     = key;
                        stored_payload[pos] = item;
                        res.status          = ST_OK;
                        res.slot            = pos[SLOT_W-1:0];
                        done                = 1'b1;
                    end else begin
                        pos = (pos + 1) % SLOTS;
                    end
                end
                if (!done) fulls++;
            end
            OP_SEARCH: begin
                res.status = ST_MISS;
                for (int n = 0; n < SLOTS && !done; n++) begin
                    if (!occupied[pos]) begin
                        done = 1'b1;
                    end else if (stored_key[pos] == key) begin
                        res.status  = ST_OK;
                        res.slot    = pos[SLOT_W-1:0];
                        res.payload = stored_payload[pos];
                        done        = 1'b1;
                    end else begin
                        pos = (pos + 1) % SLOTS;
                    end
                end
                if (res.status == ST_OK) hits++;
                else misses++;
            end
            default: ;
        endcase
        return res;
    endfunction

    task automatic note_mismatch(input string field, input logic [31:0] want,
                                 input logic [31:0] seen);
        fail_count++;
        $display("%0t: result %0d %s mismatch: expected %0h, actual %0h",
                 $time, checked, field, want, seen);
    endtask

    always @(posedge i_clk) begin : watch
        t_lookup want;
        t_lookup got;
        if (!i_rst_n) begin
            for (int i = 0; i < SLOTS; i++) occupied[i] = 1'b0;
            expected_q.delete();
        end else begin
            if (i_req_valid && i_req_ready)
                expected_q.push_back(apply_request(
                    i_req_data[OPCODE_W-1:0],
                    i_req_data[OPCODE_W +: KEY_W],
                    i_req_data[OPCODE_W+KEY_W +: IN_DATA_W]));
            if (i_res_valid && i_res_ready) begin
                got.status  = t_status'(i_res_data[STATUS_W-1:0]);
                got.slot    = i_res_data[STATUS_W +: SLOT_W];
                got.payload = i_res_data[STATUS_W+SLOT_W +: OUT_DATA_W];
                if (expected_q.size() == 0) begin
                    fail_count++;
                    $display("%0t: unexpected result, expected none, actual %0h",
                             $time, i_res_data);
                end else begin
                    want = expected_q.pop_front();
                    if (got.status != want.status)
                        note_mismatch("status", 32'(want.status), 32'(got.status));
                    if (got.slot != want.slot)
                        note_mismatch("slot_index", 32'(want.slot), 32'(got.slot));
                    if (got.payload != want.payload)
                        note_mismatch("data_out", want.payload, got.payload);
                end
                checked++;
            end
        end
        o_fail_count <= fail_count;
        o_pending    <= expected_q.size();
        o_checked    <= checked;
        o_hits       <= hits;
        o_misses     <= misses;
        o_fulls      <= fulls;
    end

endmodule

// ===== tb/linear_probe_hash_table_top_tb.sv =====
module linear_probe_hash_table_top_tb;
    import lpht_pkg::*;

    // opcode with no operation behind it, must answer ok and change nothing
    localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;

    localparam int RANDOM_REQUESTS = 1825;
    localparam int IDLE_LIMIT      = 2000;
    localparam int DRAIN_CYCLES    = 40;
    localparam int KEY_POOL        = 24;
    localparam int SLOTS           = TABLE_SIZE_DEF;

    logic                   clk;
    logic                   rst_n     = 1'b0;
    logic                   req_valid = 1'b0;
    logic                   req_ready;
    logic [IN_TDATA_W-1:0]  req_data  = '0;
    logic                   res_valid;
    logic                   res_ready = 1'b0;
    logic [OUT_TDATA_W-1:0] res_data;

    int fail_count;
    int pending;
    int checked;
    int hits;
    int misses;
    int fulls;

    int sent        = 0;
    int n_clear     = 0;
    int n_insert    = 0;
    int n_search    = 0;
    int n_unused    = 0;
    int idle_cycles = 0;
    int rx_cycle    = 0;
    int rx_stall    = 0;

    // keys the random part draws from, so searches hit and homes collide
    logic [KEY_W-1:0] key_pool [KEY_POOL];

    linear_probe_hash_table_top u_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (req_valid),
        .o_s_axis_tready (req_ready),
        .i_s_axis_tdata  (req_data),
        .o_m_axis_tvalid (res_valid),
        .i_m_axis_tready (res_ready),
        .o_m_axis_tdata  (res_data)
    );

    lpht_result_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_req_valid  (req_valid),
        .i_req_ready  (req_ready),
        .i_req_data   (req_data),
        .i_res_valid  (res_valid),
        .i_res_ready  (res_ready),
        .i_res_data   (res_data),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked),
        .o_hits       (hits),
        .o_misses     (misses),
        .o_fulls      (fulls)
    );

    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // result side back-pressure: mostly ready, short stalls, now and then a long one,
    // and one window in every four always ready
    always @(negedge clk) begin : rx_pacing
        int r;
        rx_cycle++;
        r = $urandom_range(0, 99);
        if ((rx_cycle / 400) % 4 == 1) begin
            res_ready <= 1'b1;
        end else if (rx_stall > 0) begin
            res_ready <= 1'b0;
            rx_stall--;
        end else if (r < 80) begin
            res_ready <= 1'b1;
        end else if (r < 96) begin
            res_ready <= 1'b0;
            rx_stall = $urandom_range(0, 2);
        end else begin
            res_ready <= 1'b0;
            rx_stall = $urandom_range(14, 49);
        end
    end

    // hang detector: no request and no result taken for too long
    always @(posedge clk) begin
        if (rst_n) begin
            if ((req_valid && req_ready) || (res_valid && res_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("%0t: no handshake for %0d cycles", $time, idle_cycles);
                $display("[linear_probe_hash_table_top] ERROR");
                $finish;
            end
        end
    end

    // pause after a request: none during quiet windows, else mostly short
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if ((sent / 120) % 4 == 2) return 0;
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic refresh_key_pool();
        logic [31:0] w;
        for (int i = 0; i < KEY_POOL; i++) begin
            w           = $urandom;
            key_pool[i] = w[KEY_W-1:0];
        end
    endtask

    // mostly pool keys, sometimes a fresh random one
    function automatic logic [KEY_W-1:0] pick_key();
        logic [31:0] w;
        w = $urandom;
        if ($urandom_range(0, 9) == 0) return w[KEY_W-1:0];
        return key_pool[$urandom_range(0, KEY_POOL - 1)];
    endfunction

    // one request: valid held until taken, then an optional pause
    task automatic send_request(input logic [OPCODE_W-1:0]  op,
                                input logic [KEY_W-1:0]     key,
                                input logic [IN_DATA_W-1:0] item);
        int gap;
        @(negedge clk);
        req_valid <= 1'b1;
        req_data  <= {{(IN_TDATA_W - IN_FIELDS_W){1'b0}}, item, key, op};
        do @(posedge clk); while (!req_ready);
        sent++;
        case (op)
            OP_CLEAR:  n_clear++;
            OP_INSERT: n_insert++;
            OP_SEARCH: n_search++;
            default:   n_unused++;
        endcase
        gap = pick_gap();
        if (gap > 0) begin
            @(negedge clk);
            req_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    initial begin
        int r;
        refresh_key_pool();
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;

        // directed: wrap at the top slot, extremes of key and payload
        send_request(OP_CLEAR, '1, '1);
        send_request(OP_INSERT, '1, 32'hFFFF_FFFF);     // home 15, lands in 15
        send_request(OP_INSERT, 31'd15, 32'h0);         // home 15 taken, wraps to 0
        send_request(OP_SEARCH, 31'd15, '1);            // found after wrapping
        send_request(OP_SEARCH, '1, 32'h0);             // found at home
        send_request(OP_SEARCH, 31'd31, 32'h5A5A_A5A5); // miss on an empty slot
        send_request(OP_UNUSED, 31'd3, 32'hDEAD_BEEF);
        send_request(OP_INSERT, 31'd0, 32'h1234_5678);  // home 0 taken, goes to 1
        // fill every remaining slot
        for (int k = 2; k < SLOTS - 1; k++)
            send_request(OP_INSERT, KEY_W'(k), $urandom);
        send_request(OP_INSERT, 31'd100, 32'hCAFE_F00D); // refused, table full
        send_request(OP_SEARCH, 31'd47, 32'h0);          // absent key, every slot probed
        send_request(OP_SEARCH, 31'd0, 32'h0);           // found one past home
        send_request(OP_CLEAR, 31'd0, 32'h0);

        // random: inserts and searches over a small key pool, clears and unused opcodes now and then
        for (int i = 0; i < RANDOM_REQUESTS; i++) begin
            r = $urandom_range(0, 99);
            if (r < 3) begin
                send_request(OP_CLEAR, pick_key(), $urandom);
                refresh_key_pool();
            end else if (r < 5) begin
                send_request(OP_UNUSED, pick_key(), $urandom);
            end else if (r < 48) begin
                send_request(OP_INSERT, pick_key(), $urandom);
            end else begin
                send_request(OP_SEARCH, pick_key(), $urandom);
            end
        end

        @(negedge clk);
        req_valid <= 1'b0;
        // let the checker's count catch up with the last request, then drain
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("requests sent: %0d clear, %0d insert, %0d search, %0d unused opcode",
                 n_clear, n_insert, n_search, n_unused);
        $display("results checked: %0d, search hits %0d, misses %0d, inserts refused %0d",
                 checked, hits, misses, fulls);
        if (fail_count == 0)
            $display("[linear_probe_hash_table_top] OK");
        else
            $display("[linear_probe_hash_table_top] ERROR");
        $finish;
    end

endmodule
